### rtl/core/prqs_pkg.sv
// prqs_pkg: shared types and constants for the priority ready-queue scheduler
// no dependencies
package prqs_pkg;

  localparam int MAX_THREADS_DEF = 16;
  localparam int SLEEP_WIDTH_DEF = 32;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [1:0] ST_DEAD    = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;
  localparam logic [1:0] ST_WAITING = 2'd3;

  localparam logic [1:0] PR_IDLE   = 2'd0;
  localparam logic [1:0] PR_LOW    = 2'd1;
  localparam logic [1:0] PR_NORMAL = 2'd2;
  localparam logic [1:0] PR_HIGH   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  thread_id;
    logic [1:0]  thread_state;
    logic [1:0]  prio;
    logic [31:0] sleep_ticks;
    logic        activate;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] running_id;
    logic [3:0] previous_id;
    logic       switched;
  } out_beat_t;

endpackage

### rtl/core/prqs_fifo.sv
// prqs_fifo: circular id queue with one push or one pop per cycle
// depends on prqs_pkg
module prqs_fifo import prqs_pkg::*; #(
  parameter int DEPTH = MAX_THREADS_DEF,
  parameter int IDW   = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [IDW-1:0] push_id,
  input  logic           pop,
  output logic [IDW-1:0] head_id,
  output logic           full,
  output logic           empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [IDW-1:0] mem [DEPTH];
  logic [AW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [AW:0]    count_r, count_nxt;

  // pointer wrap at depth
  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) inc = '0;
    else inc = p + 1'b1;
  endfunction

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign head_id = mem[head_r];

  // pointer and count update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push && !full) begin
      tail_nxt  = inc(tail_r);
      count_nxt = count_r + 1'b1;
    end else if (pop && !empty) begin
      head_nxt  = inc(head_r);
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push && !full) mem[tail_r] <= push_id;
  end
endmodule

### rtl/core/priority_ready_queue_scheduler_unit.sv
// priority_ready_queue_scheduler_unit: top level with thread table and sequencer
// depends on prqs_pkg and prqs_fifo
//
// One input channel (in_valid/in_ready/in_data) and one result channel
// (out_valid/out_ready/out_data). Every input beat gives exactly one result
// beat. A write beat updates its thread entry, if the id lies inside the
// table, and goes straight to the result register. A schedule beat walks
// the thread table one entry per cycle, then passes the end-of-walk check,
// the pop, the decision, the apply step and the result register; a tick
// beat adds a countdown walk over the table before that. Both walks use
// the single entry walker, which also runs the sleep counter decrement.
// in_ready is high only while the sequencer is idle; a new beat is taken
// while the previous result still waits in the output register. A stalled
// receiver holds the result and, once the next beat has finished, holds
// the sequencer too. Reset kills every thread, empties the three queues
// and makes thread 0 the running thread.
module priority_ready_queue_scheduler_unit import prqs_pkg::*; #(
  parameter int MAX_THREADS = MAX_THREADS_DEF,
  parameter int SLEEP_WIDTH = SLEEP_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);
  localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int TW = $clog2(MAX_THREADS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [1:0]             status_r [MAX_THREADS];
  logic [1:0]             prio_r   [MAX_THREADS];
  logic [MAX_THREADS-1:0] queued_r, sleeping_r;
  logic [SLEEP_WIDTH-1:0] sleep_r  [MAX_THREADS];

  logic [2:0]    state_r;
  logic [TW-1:0] idx_r, total_r;
  logic [IW-1:0] run_r, prev_r, cur_r;
  logic          act_r, sw_r, fall_r;
  out_beat_t     res_r;
  logic          res_v_r;

  // shared per-entry view at the walker index
  logic [IW-1:0] ix;
  logic [1:0]    e_st, e_pr;
  logic [SLEEP_WIDTH-1:0] dec;
  assign ix   = idx_r[IW-1:0];
  assign e_st = status_r[ix];
  assign e_pr = prio_r[ix];
  assign dec  = sleep_r[ix] - 1'b1;

  // entry addressed by a write beat
  logic [IW-1:0] wr_ix;
  logic          wr_ok;
  assign wr_ix = IW'(in_data.thread_id);
  assign wr_ok = (32'(in_data.thread_id) < MAX_THREADS);

  // queues
  logic [2:0]    q_push, q_pop, q_full, q_empty;
  logic [IW-1:0] q_head [3];
  logic          scan_ok;
  assign scan_ok = (state_r == S_SCAN) && (idx_r < total_r) &&
                   (e_st == ST_READY) && !queued_r[ix];
  assign q_push[0] = scan_ok && (e_pr == PR_LOW);
  assign q_push[1] = scan_ok && (e_pr == PR_NORMAL);
  assign q_push[2] = scan_ok && (e_pr == PR_HIGH);
  assign q_pop[2] = (state_r == S_POP) && !q_empty[2];
  assign q_pop[1] = (state_r == S_POP) && q_empty[2] && !q_empty[1];
  assign q_pop[0] = (state_r == S_POP) && q_empty[2] && q_empty[1] && !q_empty[0];

  for (genvar g = 0; g < 3; g++) begin : g_q
    prqs_fifo #(.DEPTH(MAX_THREADS), .IDW(IW)) u_fifo (
      .clk(clk), .rst_n(rst_n), .push(q_push[g]), .push_id(ix),
      .pop(q_pop[g]), .head_id(q_head[g]), .full(q_full[g]), .empty(q_empty[g])
    );
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  logic [IW-1:0] one_id;
  assign one_id = IW'(1);

  // decision terms from the chosen and previous thread
  logic keep;
  always_comb begin
    keep = 1'b0;
    if (act_r && prio_r[cur_r] <= prio_r[prev_r]) keep = 1'b1;
    if (prio_r[cur_r] < prio_r[prev_r] && status_r[prev_r] == ST_RUNNING) keep = 1'b1;
    if (prev_r == cur_r) keep = 1'b1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_v_r    <= 1'b0;
      run_r      <= '0;
      total_r    <= '0;
      queued_r   <= '0;
      sleeping_r <= '0;
      for (int i = 0; i < MAX_THREADS; i++) begin
        status_r[i] <= ST_DEAD;
        prio_r[i]   <= PR_IDLE;
        sleep_r[i]  <= '0;
      end
    end else begin
      if (res_v_r && out_ready && state_r != S_DONE) res_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            prev_r <= run_r;
            act_r  <= (in_data.op == OP_SCHED) && in_data.activate;
            sw_r   <= 1'b0;
            idx_r  <= '0;
            if (in_data.op == OP_TICK) begin
              state_r <= S_TICK;
            end else if (in_data.op == OP_SCHED) begin
              state_r <= S_SCAN;
            end else begin
              if (in_data.op == OP_WRITE && wr_ok) begin
                status_r[wr_ix] <= in_data.thread_state;
                prio_r[wr_ix]   <= in_data.prio;
                sleep_r[wr_ix]  <= SLEEP_WIDTH'({32'd0, in_data.sleep_ticks});
                sleeping_r[wr_ix] <=
                  (in_data.thread_state == ST_WAITING) && (in_data.sleep_ticks != '0);
                if (TW'(in_data.thread_id) >= total_r)
                  total_r <= TW'(in_data.thread_id) + 1'b1;
              end
              state_r <= S_DONE;
            end
          end
        end
        S_TICK: begin
          if (idx_r >= total_r) begin
            idx_r   <= '0;
            state_r <= S_SCAN;
          end else begin
            if (e_st == ST_WAITING && sleeping_r[ix]) begin
              sleep_r[ix] <= dec;
              if (dec == '0) begin
                sleeping_r[ix] <= 1'b0;
                status_r[ix]   <= ST_READY;
              end
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SCAN: begin
          if (idx_r >= total_r) begin
            state_r <= S_POP;
          end else begin
            if ((q_push[0] && !q_full[0]) || (q_push[1] && !q_full[1]) ||
                (q_push[2] && !q_full[2]))
              queued_r[ix] <= 1'b1;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_POP: begin
          if (q_pop[2])      cur_r <= q_head[2];
          else if (q_pop[1]) cur_r <= q_head[1];
          else if (q_pop[0]) cur_r <= q_head[0];
          else               cur_r <= run_r;
          state_r <= S_DEC;
        end
        S_DEC: begin
          // candidate equals running thread: two-thread case or fallback to thread 1
          fall_r <= 1'b0;
          if (cur_r == prev_r) begin
            if (total_r == TW'(2) && status_r[0] == ST_RUNNING) begin
              run_r   <= '0;
              fall_r  <= 1'b1;
            end else begin
              cur_r <= one_id;
              queued_r[one_id] <= 1'b0;
            end
          end else begin
            queued_r[cur_r] <= 1'b0;
          end
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (!fall_r && !keep) begin
            if (status_r[prev_r] == ST_RUNNING) status_r[prev_r] <= ST_READY;
            status_r[cur_r] <= ST_RUNNING;
            run_r <= cur_r;
            sw_r  <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!res_v_r || out_ready) begin
            res_r.running_id  <= 4'(run_r);
            res_r.previous_id <= 4'(prev_r);
            res_r.switched    <= sw_r;
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### bench/tb.sv
// tb: self-checking bench for priority_ready_queue_scheduler_unit
// depends on prqs_pkg and the scheduler rtl; carries its own scheduler predictor
`timescale 1ns / 100ps

module tb;
  import prqs_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         N_THREADS  = 16;
  localparam int         N_RANDOM   = 600;
  localparam int         QUIET_TAIL = 80;
  localparam int         PAUSE_AT   = 300;
  localparam int         HOLD_AT    = 150;
  localparam int         HOLD_LEN   = 300;
  localparam int         WDOG_LIMIT = 3000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  priority_ready_queue_scheduler_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state: thread table, three ready queues, running thread
  logic [1:0]  pm_status  [N_THREADS];
  logic [1:0]  pm_prio    [N_THREADS];
  logic        pm_queued  [N_THREADS];
  logic        pm_asleep  [N_THREADS];
  logic [31:0] pm_left    [N_THREADS];
  logic [3:0]  rq_slot    [3][N_THREADS];
  int          rq_head    [3];
  int          rq_count   [3];
  logic [3:0]  pm_running;
  int          pm_total;

  in_beat_t  pending_q[$];
  out_beat_t sched_expect_q[$];
  int        n_errors;
  int        n_sent;
  int        n_results;

  // ready queue index per priority: 0 low, 1 normal, 2 high
  function automatic logic sched_pass(input logic act);
    logic [3:0] prev, cur;
    int         q;
    prev = pm_running;
    cur  = prev;
    for (int i = 0; i < pm_total; i++) begin
      if (pm_status[i] == ST_READY && !pm_queued[i] && pm_prio[i] != PR_IDLE) begin
        q = int'(pm_prio[i]) - 1;
        if (rq_count[q] < N_THREADS) begin
          rq_slot[q][(rq_head[q] + rq_count[q]) % N_THREADS] = i[3:0];
          rq_count[q]++;
          pm_queued[i] = 1'b1;
        end
      end
    end
    for (q = 2; q >= 0; q--) begin
      if (rq_count[q] > 0) begin
        cur = rq_slot[q][rq_head[q]];
        rq_head[q] = (rq_head[q] + 1) % N_THREADS;
        rq_count[q]--;
        break;
      end
    end
    if (cur == prev) begin
      if (pm_total == 2 && pm_status[0] == ST_RUNNING) begin
        pm_running = 4'd0;
        return 1'b0;
      end
      cur = 4'd1;
    end
    pm_queued[cur] = 1'b0;
    if (act && pm_prio[cur] <= pm_prio[prev]) return 1'b0;
    if (pm_prio[cur] < pm_prio[prev] && pm_status[prev] == ST_RUNNING) return 1'b0;
    if (prev == cur) return 1'b0;
    if (pm_status[prev] == ST_RUNNING) pm_status[prev] = ST_READY;
    pm_status[cur] = ST_RUNNING;
    pm_running = cur;
    return 1'b1;
  endfunction

  function automatic out_beat_t predict_beat(input in_beat_t b);
    out_beat_t r;
    r.previous_id = pm_running;
    r.switched    = 1'b0;
    case (b.op)
      OP_TICK: begin
        for (int i = 0; i < pm_total; i++) begin
          if (pm_status[i] == ST_WAITING && pm_asleep[i]) begin
            pm_left[i] = pm_left[i] - 32'd1;
            if (pm_left[i] == 32'd0) begin
              pm_asleep[i] = 1'b0;
              pm_status[i] = ST_READY;
            end
          end
        end
        r.switched = sched_pass(1'b0);
      end
      OP_SCHED: r.switched = sched_pass(b.activate);
      OP_WRITE: begin
        pm_status[b.thread_id] = b.thread_state;
        pm_prio[b.thread_id]   = b.prio;
        pm_left[b.thread_id]   = b.sleep_ticks;
        pm_asleep[b.thread_id] = (b.thread_state == ST_WAITING) && (b.sleep_ticks != 0);
        if (int'(b.thread_id) + 1 > pm_total) pm_total = int'(b.thread_id) + 1;
      end
      default: ;
    endcase
    r.running_id = pm_running;
    return r;
  endfunction

  function automatic in_beat_t make_beat(input logic [1:0] op, input int id,
                                         input logic [1:0] st, input logic [1:0] pr,
                                         input logic [31:0] sl, input logic act);
    in_beat_t b;
    b.op = op; b.thread_id = id[3:0]; b.thread_state = st;
    b.prio = pr; b.sleep_ticks = sl; b.activate = act;
    return b;
  endfunction

  // random beat: table writes, schedules, ticks and some unused ops, mostly with short sleeps
  function automatic in_beat_t random_beat();
    in_beat_t b;
    int       w;
    b = make_beat(OP_WRITE, int'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 32'($urandom_range(1, 3)),
                  1'($urandom_range(0, 1)));
    w = $urandom_range(0, 99);
    if (w < 30) b.op = OP_SCHED;
    else if (w < 55) b.op = OP_TICK;
    else if (w < 60) b.op = OP_UNUSED;
    else begin
      w = $urandom_range(0, 9);
      if (w < 4) b.thread_state = ST_READY;
      else if (w < 7) b.thread_state = ST_WAITING;
    end
    w = $urandom_range(0, 9);
    if (w == 0) b.sleep_ticks = $urandom;
    else if (w == 1) b.sleep_ticks = 32'd0;
    return b;
  endfunction

  // append one beat to the stimulus queue
  task automatic add_beat(input in_beat_t b);
    pending_q.insert(pending_q.size(), b);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("result %0d: %s got %0d expected %0d", n_results, what, got, want);
    n_errors++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // reset and stimulus
  initial begin
    n_errors = 0;
    rst_n = 1'b0;
    for (int i = 0; i < N_THREADS; i++) begin
      pm_status[i] = ST_DEAD; pm_prio[i] = PR_IDLE; pm_queued[i] = 1'b0;
      pm_asleep[i] = 1'b0; pm_left[i] = '0;
    end
    for (int q = 0; q < 3; q++) begin
      rq_head[q] = 0; rq_count[q] = 0;
    end
    pm_running = '0;
    pm_total   = 0;

    // two-thread table keeps thread 0
    add_beat(make_beat(OP_UNUSED, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b0));
    add_beat(make_beat(OP_WRITE, 0, ST_RUNNING, PR_LOW, 32'd0, 1'b0));
    add_beat(make_beat(OP_WRITE, 1, ST_READY, PR_IDLE, 32'd0, 1'b0));
    add_beat(make_beat(OP_SCHED, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b1));
    add_beat(make_beat(OP_TICK, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b0));
    // activation: higher priority preempts, equal one does not
    add_beat(make_beat(OP_WRITE, 2, ST_READY, PR_HIGH, 32'hFFFF_FFFF, 1'b1));
    add_beat(make_beat(OP_SCHED, 15, ST_WAITING, PR_HIGH, 32'hFFFF_FFFF, 1'b1));
    add_beat(make_beat(OP_WRITE, 3, ST_READY, PR_HIGH, 32'd0, 1'b0));
    add_beat(make_beat(OP_SCHED, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b1));
    add_beat(make_beat(OP_WRITE, 4, ST_READY, PR_NORMAL, 32'd0, 1'b0));
    add_beat(make_beat(OP_SCHED, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b0));
    // sleepers: short countdown, zero count, and a full-width one
    add_beat(make_beat(OP_WRITE, 5, ST_WAITING, PR_LOW, 32'd2, 1'b0));
    add_beat(make_beat(OP_WRITE, 6, ST_WAITING, PR_HIGH, 32'd0, 1'b0));
    add_beat(make_beat(OP_WRITE, 15, ST_WAITING, PR_NORMAL, 32'hFFFF_FFFF, 1'b1));
    add_beat(make_beat(OP_TICK, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b1));
    add_beat(make_beat(OP_TICK, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b0));
    add_beat(make_beat(OP_WRITE, 7, ST_READY, PR_IDLE, 32'd0, 1'b0));
    add_beat(make_beat(OP_WRITE, 8, ST_DEAD, PR_HIGH, 32'd5, 1'b0));
    add_beat(make_beat(OP_SCHED, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b0));
    add_beat(make_beat(OP_SCHED, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b0));
    add_beat(make_beat(OP_TICK, 0, ST_DEAD, PR_IDLE, 32'd0, 1'b0));
    for (int k = 0; k < N_RANDOM; k++) add_beat(random_beat());

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_q.size() == 0 && !in_valid && sched_expect_q.size() == 0);
    repeat (60) @(posedge clk);
    if (n_errors == 0 && sched_expect_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // sender: random idle bursts, one pause until the queue drains
  int   send_gap;
  logic drain_pause;
  always @(posedge clk) begin
    logic     nv;
    in_beat_t b;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_data     <= '0;
      send_gap    <= 0;
      drain_pause <= 1'b0;
      n_sent      <= 0;
    end else if (!in_valid || in_ready) begin
      nv = 1'b0;
      if (in_valid) begin
        sched_expect_q.insert(sched_expect_q.size(), predict_beat(in_data));
        n_sent <= n_sent + 1;
        if (n_sent + 1 == PAUSE_AT) drain_pause <= 1'b1;
      end
      if (drain_pause && !in_valid && sched_expect_q.size() == 0) begin
        drain_pause <= 1'b0;
      end else if (drain_pause || (in_valid && n_sent + 1 == PAUSE_AT)) begin
        nv = 1'b0;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_q.size() > 0) begin
        b = pending_q.pop_front();
        in_data <= b;
        nv = 1'b1;
        if (pending_q.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          send_gap <= $urandom_range(1, 5);
      end
      in_valid <= nv;
    end
  end

  // receiver: random stall bursts and one long hold-off
  int hold_cnt;
  int recv_gap;
  logic hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
      recv_gap  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_results >= HOLD_AT) begin
      out_ready <= 1'b0;
      if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
      else hold_cnt <= hold_cnt + 1;
    end else if (recv_gap > 0) begin
      out_ready <= 1'b0;
      recv_gap  <= recv_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if (pending_q.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
        recv_gap <= $urandom_range(1, 5);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      n_results <= 0;
    end else if (out_valid && out_ready) begin
      if (sched_expect_q.size() == 0) begin
        $display("result %0d: beat with nothing expected", n_results);
        n_errors++;
      end else begin
        want = sched_expect_q.pop_front();
        if (out_data.running_id != want.running_id)
          report_mismatch("running_id", out_data.running_id, want.running_id);
        if (out_data.previous_id != want.previous_id)
          report_mismatch("previous_id", out_data.previous_id, want.previous_id);
        if (out_data.switched != want.switched)
          report_mismatch("switched", out_data.switched, want.switched);
      end
      n_results <= n_results + 1;
    end
  end

  // watchdog on cycles with no beat moving
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### files.f
rtl/core/prqs_pkg.sv
rtl/core/prqs_fifo.sv
rtl/core/priority_ready_queue_scheduler_unit.sv
bench/tb.sv
